// ----- rtl/mes_pkg.sv -----
// Shared types and constants for the multi-turn encoder speed block.
`default_nettype none
package mes_pkg;

  // Fixed field widths
  localparam int RAW_W      = 12;
  localparam int ANGLE_EXT_W = 16;
  localparam int INTERVAL_W = 16;
  localparam int TOTAL_W    = 29;
  localparam int SGAIN_W    = 24;
  localparam int WORD_W     = 32;
  localparam int DIR_W      = 3;
  localparam int CFG_IDX_W  = 2;

  // Multiplier operand and product widths
  localparam int OPA_W  = TOTAL_W + 1;
  localparam int OPB_W  = WORD_W + 1;
  localparam int PROD_W = OPA_W + OPB_W;

  // Speed divider: dividend is (magnitude * gain) >> 8
  localparam int SPD_SHIFT   = 8;
  localparam int SPD_PROD_W  = TOTAL_W + SGAIN_W;
  localparam int DIV_STEPS   = SPD_PROD_W - SPD_SHIFT;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int REM_W       = INTERVAL_W + 1;

  // Weight rounding
  localparam int WGT_SHIFT = 16;
  localparam int WGT_Q_W   = PROD_W - WGT_SHIFT;
  localparam int WGT_SUM_W = WGT_Q_W + 1;

  // Direction codes
  localparam logic [DIR_W-1:0] DIR_STOP      = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP        = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN      = 3'd2;
  localparam logic [DIR_W-1:0] DIR_WRAP_UP   = 3'd3;
  localparam logic [DIR_W-1:0] DIR_WRAP_DOWN = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_OFFSET = 2'd2;

  // Configuration reset values
  localparam logic [SGAIN_W-1:0]       SPEED_GAIN_RST    = 24'd120187;
  localparam logic signed [WORD_W-1:0] WEIGHT_GAIN_RST   = 32'sd25141;
  localparam logic signed [WORD_W-1:0] WEIGHT_OFFSET_RST = -32'sd4863;

  // Controller states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL_W,
    ST_RND,
    ST_SUM,
    ST_MUL_S,
    ST_DIV_INIT,
    ST_DIV,
    ST_FIN
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;
    logic calc;
    logic mul_w;
    logic rnd;
    logic sum;
    logic mul_s;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic skip_div;
    logic div_done;
    logic out_free;
  } status_t;

endpackage
`default_nettype wire

// ----- rtl/mes_ctrl.sv -----
// Controller state machine sequencing one item through the datapath.
`default_nettype none
module mes_ctrl (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           s_tvalid,
  output logic                s_tready,
  input  wire mes_pkg::status_t sts,
  output mes_pkg::cmd_t       cmd
);
  import mes_pkg::*;

  ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // Take no item while reset is held
        if (!rst) begin
          s_tready = 1'b1;
          if (s_tvalid) begin
            cmd.accept = 1'b1;
            state_next = ST_CALC;
          end
        end
      end
      ST_CALC: begin
        cmd.calc   = 1'b1;
        state_next = ST_MUL_W;
      end
      ST_MUL_W: begin
        cmd.mul_w  = 1'b1;
        state_next = ST_RND;
      end
      ST_RND: begin
        cmd.rnd    = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum    = 1'b1;
        state_next = ST_MUL_S;
      end
      ST_MUL_S: begin
        cmd.mul_s  = 1'b1;
        state_next = sts.skip_div ? ST_FIN : ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/mes_dpath.sv -----
// Datapath: unwrap state, shared multiplier, speed divider, result register.
`default_nettype none
module mes_dpath #(
  parameter int TURN_BITS  = 16,
  parameter int ANGLE_BITS = 12
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire mes_pkg::cmd_t                        cmd,
  output mes_pkg::status_t                          sts,
  input  wire logic [mes_pkg::RAW_W-1:0]            raw_angle,
  input  wire logic [mes_pkg::INTERVAL_W-1:0]       interval_ms,
  input  wire logic                                 capture_origin,
  input  wire logic                                 cfg_we,
  input  wire logic [mes_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [mes_pkg::WORD_W-1:0]           cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [mes_pkg::DIR_W-1:0]                 direction,
  output logic signed [mes_pkg::TOTAL_W-1:0]        total_count,
  output logic signed [mes_pkg::WORD_W-1:0]         speed_value,
  output logic signed [mes_pkg::WORD_W-1:0]         weight_value,
  output logic                                      div_fault
);
  import mes_pkg::*;

  localparam logic signed [ANGLE_BITS:0] HALF     = (ANGLE_BITS+1)'(1) << (ANGLE_BITS - 1);
  localparam logic signed [ANGLE_BITS:0] NEG_HALF = -HALF;

  // Configuration registers
  logic [SGAIN_W-1:0]       speed_gain;
  logic signed [WORD_W-1:0] weight_gain;
  logic signed [WORD_W-1:0] weight_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain    <= SPEED_GAIN_RST;
      weight_gain   <= WEIGHT_GAIN_RST;
      weight_offset <= WEIGHT_OFFSET_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPEED_GAIN:    speed_gain    <= cfg_data[SGAIN_W-1:0];
        REG_WEIGHT_GAIN:   weight_gain   <= cfg_data;
        REG_WEIGHT_OFFSET: weight_offset <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input item hold
  logic [ANGLE_BITS-1:0] angle;
  logic [INTERVAL_W-1:0] interval;
  logic                  cap;
  logic [ANGLE_EXT_W-1:0] raw_ext;

  assign raw_ext = {{(ANGLE_EXT_W-RAW_W){1'b0}}, raw_angle};

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      angle    <= raw_ext[ANGLE_BITS-1:0];
      interval <= interval_ms;
      cap      <= capture_origin;
    end
  end

  // Unwrap state
  logic [ANGLE_BITS-1:0]     last_angle;
  logic [ANGLE_BITS-1:0]     origin_angle;
  logic [TURN_BITS-1:0]      turn_count;
  logic signed [TOTAL_W-1:0] prev_total;

  // Step classification
  logic signed [ANGLE_BITS:0] diff;
  logic [DIR_W-1:0]           dir_next;
  logic [TURN_BITS-1:0]       turn_next;

  assign diff = signed'({1'b0, angle}) - signed'({1'b0, last_angle});

  always_comb begin
    dir_next  = DIR_STOP;
    turn_next = turn_count;
    if (cap) begin
      dir_next = DIR_STOP;
    end else if (diff < NEG_HALF) begin
      dir_next  = DIR_WRAP_UP;
      turn_next = turn_count + TURN_BITS'(1);
    end else if (diff > HALF) begin
      dir_next  = DIR_WRAP_DOWN;
      turn_next = turn_count - TURN_BITS'(1);
    end else if (diff > 0) begin
      dir_next = DIR_UP;
    end else if (diff < 0) begin
      dir_next = DIR_DOWN;
    end
  end

  // Unwrapped total, modulo 2^TOTAL_W
  logic [63:0]               turn_wide;
  logic [ANGLE_BITS-1:0]     origin_next;
  logic [TOTAL_W-1:0]        total_next;
  logic signed [TOTAL_W:0]   delta;
  logic [TOTAL_W-1:0]        delta_mag;

  assign origin_next = cap ? angle : origin_angle;
  assign turn_wide   = {{(64-TURN_BITS){turn_next[TURN_BITS-1]}}, turn_next} << ANGLE_BITS;
  assign total_next  = turn_wide[TOTAL_W-1:0] + TOTAL_W'(angle) - TOTAL_W'(origin_next);
  assign delta       = signed'({total_next[TOTAL_W-1], total_next})
                     - signed'({prev_total[TOTAL_W-1], prev_total});
  assign delta_mag   = delta[TOTAL_W] ? TOTAL_W'(-delta) : delta[TOTAL_W-1:0];

  logic signed [TOTAL_W-1:0] total;
  logic [DIR_W-1:0]          dir;
  logic [TOTAL_W-1:0]        mag;
  logic                      neg;

  // Update unwrap state and hold the item's total and delta
  always_ff @(posedge clk) begin
    if (rst) begin
      last_angle   <= '0;
      origin_angle <= '0;
      turn_count   <= '0;
      prev_total   <= '0;
    end else if (cmd.calc) begin
      last_angle   <= angle;
      origin_angle <= origin_next;
      turn_count   <= turn_next;
      if (!cap) begin
        prev_total <= total_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      total <= total_next;
      dir   <= dir_next;
      mag   <= delta_mag;
      neg   <= delta[TOTAL_W];
    end
  end

  // Shared multiplier: weight product, then speed product
  logic signed [OPA_W-1:0]  op_a;
  logic signed [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;

  assign op_a = cmd.mul_s ? signed'({1'b0, mag}) : signed'({total[TOTAL_W-1], total});
  assign op_b = cmd.mul_s ? signed'({{(OPB_W-SGAIN_W){1'b0}}, speed_gain})
                          : signed'({weight_gain[WORD_W-1], weight_gain});

  always_ff @(posedge clk) begin
    if (cmd.mul_w || cmd.mul_s) begin
      prod <= op_a * op_b;
    end
  end

  // Weight: round half up, add offset, saturate
  logic signed [PROD_W-1:0]    prod_rnd;
  logic signed [WGT_Q_W-1:0]   wq;
  logic signed [WGT_SUM_W-1:0] wsum;
  logic signed [WORD_W-1:0]    weight;

  assign prod_rnd = prod + PROD_W'(32768);
  assign wsum     = signed'({wq[WGT_Q_W-1], wq})
                  + WGT_SUM_W'(weight_offset);

  always_ff @(posedge clk) begin
    if (cmd.rnd) begin
      wq <= WGT_Q_W'(prod_rnd >>> WGT_SHIFT);
    end
    if (cmd.sum) begin
      if (wsum > WGT_SUM_W'(32'sh7FFFFFFF)) begin
        weight <= 32'sh7FFFFFFF;
      end else if (wsum < WGT_SUM_W'(-33'sh80000000)) begin
        weight <= 32'sh80000000;
      end else begin
        weight <= wsum[WORD_W-1:0];
      end
    end
  end

  // Restoring divider, one quotient bit per cycle
  logic [REM_W-1:0]     rem;
  logic [DIV_STEPS-1:0] dq;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [REM_W-1:0]     trial;
  logic                 ge;

  assign trial = {rem[REM_W-2:0], dq[DIV_STEPS-1]};
  assign ge    = trial >= {1'b0, interval};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem     <= '0;
      dq      <= prod[SPD_PROD_W-1:SPD_SHIFT];
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? trial - {1'b0, interval} : trial;
      dq      <= {dq[DIV_STEPS-2:0], ge};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
  end

  // Saturate the quotient to a signed word
  logic                     q_big;
  logic signed [WORD_W-1:0] speed_sat;
  logic                     zero_int;

  assign zero_int = (interval == '0);
  assign q_big    = |dq[DIV_STEPS-1:WORD_W-1];

  always_comb begin
    if (neg) begin
      speed_sat = q_big ? 32'sh80000000 : -signed'(dq[WORD_W-1:0]);
    end else begin
      speed_sat = q_big ? 32'sh7FFFFFFF : signed'(dq[WORD_W-1:0]);
    end
  end

  // Status
  assign sts.skip_div = cap || zero_int;
  assign sts.div_done = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
  assign sts.out_free = !out_valid || out_ready;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      direction    <= dir;
      total_count  <= total;
      speed_value  <= (cap || zero_int) ? '0 : speed_sat;
      weight_value <= weight;
      div_fault    <= !cap && zero_int;
    end
  end

  // Never overwrite a result that has not been taken
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

  // The divider runs only with a nonzero divisor
  assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (!cap && !zero_int))
    else $error("divider stepped on a skipped item");

  // Remainder stays below the divisor after every step
  assert property (@(posedge clk) disable iff (rst)
    $past(cmd.div_step) && !$past(rst) |-> (rem < {1'b0, interval}))
    else $error("divider remainder out of range");

endmodule
`default_nettype wire

// ----- rtl/multiturn_encoder_speed.sv -----
// From item accept to result valid an item passes 6 setup steps, 45 divide steps and the load.
// The next item is taken only once the last result is loaded; the divider takes the most steps.
// Items with capture or a zero interval skip the divider: the speed product goes on to the load.
// A finished result waits in an output register while the next item is accepted.
// Reset (rst, synchronous) clears turn count, origin, last angle and previous total,
// and restores the gain and offset registers to their defaults.
`default_nettype none
module multiturn_encoder_speed #(
  parameter int TURN_BITS  = 16,
  parameter int ANGLE_BITS = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input items
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // raw_angle[11:0], interval_ms[27:12], zero[31:28]
  input  wire logic        s_tuser,   // capture_origin
  // Result items
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [95:0]      m_tdata,   // direction[2:0], total_count[31:3],
                                      // speed_value[63:32], weight_value[95:64]
  output logic             m_tuser,   // div_fault
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);
  import mes_pkg::*;

  cmd_t    cmd;
  status_t sts;

  logic [DIR_W-1:0]          direction;
  logic signed [TOTAL_W-1:0] total_count;
  logic signed [WORD_W-1:0]  speed_value;
  logic signed [WORD_W-1:0]  weight_value;

  // Take no register write while reset is held
  assign cfg_ready = !rst;

  mes_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  mes_dpath #(
    .TURN_BITS  (TURN_BITS),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .raw_angle      (s_tdata[RAW_W-1:0]),
    .interval_ms    (s_tdata[RAW_W+INTERVAL_W-1:RAW_W]),
    .capture_origin (s_tuser),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .direction      (direction),
    .total_count    (total_count),
    .speed_value    (speed_value),
    .weight_value   (weight_value),
    .div_fault      (m_tuser)
  );

  // Pack the result item
  assign m_tdata = {weight_value, speed_value, total_count, direction};

endmodule
`default_nettype wire
